>>> hdl/instruction_length_branch_predecoder_macros.svh
// Assertion macros used by the predecoder top-level RTL file.
`ifndef INSTRUCTION_LENGTH_BRANCH_PREDECODER_MACROS_SVH
`define INSTRUCTION_LENGTH_BRANCH_PREDECODER_MACROS_SVH

`ifndef SYNTHESIS
// Assert a property on the rising clock edge, disabled while reset is low.
`define ILBP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Assert a property on the rising clock edge, also checked during reset.
`define ILBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ILBP_ASSERT(lbl, clk, rstn, prop, msg)
`define ILBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hdl/ilbp_pkg.sv
// Package with the opcode constants and item types of the predecoder.
`default_nettype none
package ilbp_pkg;

  // Stream data widths in bits.
  localparam int unsigned InTdataW  = 64;
  localparam int unsigned OutTdataW = 32;

  // Primary opcodes that need individual treatment.
  localparam logic [7:0] OpNop     = 8'h00;
  localparam logic [7:0] OpLen2A   = 8'h01;
  localparam logic [7:0] OpLen2B   = 8'h02;
  localparam logic [7:0] OpPjsr    = 8'h03;
  localparam logic [7:0] OpGen04   = 8'h04;
  localparam logic [7:0] OpGen05   = 8'h05;
  localparam logic [7:0] OpLen2C   = 8'h06;
  localparam logic [7:0] OpLen2D   = 8'h07;
  localparam logic [7:0] OpLen2E   = 8'h08;
  localparam logic [7:0] OpRte     = 8'h0a;
  localparam logic [7:0] OpGen0C   = 8'h0c;
  localparam logic [7:0] OpGen0D   = 8'h0d;
  localparam logic [7:0] OpBsr8    = 8'h0e;
  localparam logic [7:0] OpJmp     = 8'h10;
  localparam logic [7:0] OpLen2F   = 8'h11;
  localparam logic [7:0] OpLen2G   = 8'h12;
  localparam logic [7:0] OpPjmp    = 8'h13;
  localparam logic [7:0] OpLen2H   = 8'h14;
  localparam logic [7:0] OpGen15   = 8'h15;
  localparam logic [7:0] OpJsr     = 8'h18;
  localparam logic [7:0] OpRts     = 8'h19;
  localparam logic [7:0] OpSleep   = 8'h1a;
  localparam logic [7:0] OpLen2I   = 8'h1c;
  localparam logic [7:0] OpGen1D   = 8'h1d;
  localparam logic [7:0] OpBsr16   = 8'h1e;

  // Opcode ranges.
  localparam logic [7:0] OpBra8Lo  = 8'h20;
  localparam logic [7:0] OpBra8Hi  = 8'h2f;
  localparam logic [7:0] OpBra16Lo = 8'h30;
  localparam logic [7:0] OpBra16Hi = 8'h3f;
  localparam logic [7:0] OpImmLo   = 8'h40;
  localparam logic [7:0] OpImmHi   = 8'h4f;
  localparam logic [7:0] OpShrtLo  = 8'h50;
  localparam logic [7:0] OpShrtHi  = 8'h57;
  localparam logic [7:0] OpWideLo  = 8'h58;
  localparam logic [7:0] OpWideHi  = 8'h5f;
  localparam logic [7:0] OpRegLo   = 8'h60;
  localparam logic [7:0] OpRegHi   = 8'h9f;
  localparam logic [7:0] OpGenLo   = 8'ha0;
  localparam logic [7:0] OpGenHi   = 8'hff;

  // High nibbles of the general format that set the displacement size.
  localparam logic [3:0] TopZero   = 4'h0;
  localparam logic [3:0] TopOne    = 4'h1;
  localparam logic [3:0] TopDisp8  = 4'he;
  localparam logic [3:0] TopDisp16 = 4'hf;

  // One input item: instruction address and five code bytes.
  typedef struct packed {
    logic [7:0]  byte4;
    logic [7:0]  byte3;
    logic [7:0]  byte2;
    logic [7:0]  byte1;
    logic [7:0]  byte0;
    logic [15:0] pc_offset;
    logic [3:0]  code_page;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        is_unconditional;
    logic        is_return;
    logic        is_call;
    logic [15:0] target_offset;
    logic [7:0]  target_page;
    logic        target_valid;
    logic [2:0]  instr_length;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/ilbp_decode.sv
// Combinational opcode decoder: length, target and flow flags of one item.
`default_nettype none
module ilbp_decode
  import ilbp_pkg::*;
(
  input  item_t   item_i,
  output result_t result_o
);

  logic [7:0]  op;
  logic [15:0] rel8_target;
  logic [15:0] rel16_target;
  logic [1:0]  ext_n;
  logic [7:0]  ext_byte;
  logic [2:0]  gen_length;

  assign op = item_i.byte0;

  // Program-counter relative targets wrap within the 16-bit offset.
  assign rel8_target  = item_i.pc_offset + 16'd2 + {{8{item_i.byte1[7]}}, item_i.byte1};
  assign rel16_target = item_i.pc_offset + 16'd3 + {item_i.byte1, item_i.byte2};

  // Displacement size of the general addressing format.
  always_comb begin
    ext_n = 2'd0;
    if (op[7:4] == TopDisp8) begin
      ext_n = 2'd1;
    end else if (op[7:4] == TopDisp16) begin
      ext_n = 2'd2;
    end else if (op[7:4] == TopZero && op[2:0] == 3'd5) begin
      ext_n = 2'd1;
    end else if (op[7:4] == TopZero && op[2:0] == 3'd4) begin
      ext_n = op[3] ? 2'd2 : 2'd1;
    end else if (op[7:4] == TopOne && op[2:0] == 3'd5) begin
      ext_n = 2'd2;
    end
  end

  // A zero operation byte after the displacement adds an extension byte.
  always_comb begin
    unique case (ext_n)
      2'd0:    ext_byte = item_i.byte1;
      2'd1:    ext_byte = item_i.byte2;
      default: ext_byte = item_i.byte3;
    endcase
    gen_length = 3'd2 + {1'b0, ext_n} + {2'b00, (ext_byte == 8'h00)};
  end

  // Primary opcode decode.
  always_comb begin
    result_o = '0;
    result_o.instr_length = 3'd1;
    unique case (op) inside
      OpLen2A, OpLen2B, OpLen2C, OpLen2D, OpLen2E, OpLen2F, OpLen2G,
      OpLen2H, OpLen2I: begin
        result_o.instr_length = 3'd2;
      end
      OpJmp, OpJsr: begin
        result_o.instr_length     = 3'd3;
        result_o.target_valid     = 1'b1;
        result_o.target_page      = {4'h0, item_i.code_page};
        result_o.target_offset    = {item_i.byte1, item_i.byte2};
        result_o.is_unconditional = (op == OpJmp);
        result_o.is_call          = (op == OpJsr);
      end
      OpPjsr, OpPjmp: begin
        result_o.instr_length     = 3'd4;
        result_o.target_valid     = 1'b1;
        result_o.target_page      = item_i.byte1;
        result_o.target_offset    = {item_i.byte2, item_i.byte3};
        result_o.is_call          = (op == OpPjsr);
        result_o.is_unconditional = (op == OpPjmp);
      end
      OpRte, OpRts: begin
        result_o.is_return = 1'b1;
      end
      OpBsr8, [OpBra8Lo:OpBra8Hi]: begin
        result_o.instr_length  = 3'd2;
        result_o.target_valid  = 1'b1;
        result_o.target_page   = {4'h0, item_i.code_page};
        result_o.target_offset = rel8_target;
      end
      OpBsr16, [OpBra16Lo:OpBra16Hi]: begin
        result_o.instr_length  = 3'd3;
        result_o.target_valid  = 1'b1;
        result_o.target_page   = {4'h0, item_i.code_page};
        result_o.target_offset = rel16_target;
      end
      [OpImmLo:OpImmHi]: begin
        result_o.instr_length = op[3] ? 3'd3 : 3'd2;
      end
      [OpShrtLo:OpShrtHi], [OpRegLo:OpRegHi]: begin
        result_o.instr_length = 3'd2;
      end
      [OpWideLo:OpWideHi]: begin
        result_o.instr_length = 3'd3;
      end
      OpGen04, OpGen05, OpGen0C, OpGen0D, OpGen15, OpGen1D, [OpGenLo:OpGenHi]: begin
        result_o.instr_length = gen_length;
      end
      default: begin
        // No-operation, sleep and unknown opcodes: one byte, no flags.
        result_o.instr_length = 3'd1;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/instruction_length_branch_predecoder.sv
// Top level of the instruction length and branch predecoder.
// The item is held in the input register, decoded by the combinational opcode
// decoder and held in the result register before it is valid on the master side.
// Throughput: one item per cycle while the master side does not stall, set by
// the input and result registers that enclose the combinational opcode decoder.
// Reset: rst_ni clears both stage valid flags; no result is pending after reset.
`default_nettype none
`include "instruction_length_branch_predecoder_macros.svh"
module instruction_length_branch_predecoder
  import ilbp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata fields from bit 0: code_page[3:0], pc_offset[19:4], byte0[27:20],
  // byte1[35:28], byte2[43:36], byte3[51:44], byte4[59:52], zero fill.
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // tdata fields from bit 0: instr_length[2:0], target_valid[3],
  // target_page[11:4], target_offset[27:12], is_call[28], is_return[29],
  // is_unconditional[30], zero fill.
  output logic [OutTdataW-1:0]      m_axis_tdata_o
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_result_q;
  result_t dec_result;
  logic    out_load;
  logic    in_load;

  // The result register loads when it is empty or being drained.
  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign in_load         = !in_valid_q || out_load;
  assign s_axis_tready_o = in_load;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid_i) begin
      in_item_q <= item_t'(s_axis_tdata_i[$bits(item_t)-1:0]);
    end
  end

  ilbp_decode u_decode (
    .item_i   (in_item_q),
    .result_o (dec_result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      out_result_q <= dec_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataW - $bits(result_t)){1'b0}}, out_result_q};

  // A stalled result keeps the item in the input register as well.
  `ILBP_ASSERT(a_stall_holds_input, clk_i, rst_ni,
    (in_valid_q && out_valid_q && !m_axis_tready_i) |=> in_valid_q,
    "input item lost during output stall")
  // Lengths stay within one to five bytes.
  `ILBP_ASSERT(a_length_range, clk_i, rst_ni,
    out_valid_q |-> (out_result_q.instr_length != 3'd0 &&
                     out_result_q.instr_length <= 3'd5),
    "instruction length out of range")
  // Target fields are zero when there is no target.
  `ILBP_ASSERT(a_no_target_zero, clk_i, rst_ni,
    (out_valid_q && !out_result_q.target_valid) |->
      (out_result_q.target_page == 8'h00 && out_result_q.target_offset == 16'h0000),
    "target fields set without target")
  // Flow flags are exclusive, and calls and jumps carry a target.
  `ILBP_ASSERT(a_flags_exclusive, clk_i, rst_ni,
    out_valid_q |-> ($onehot0({out_result_q.is_call, out_result_q.is_return,
                               out_result_q.is_unconditional}) &&
                     ((!out_result_q.is_call && !out_result_q.is_unconditional) ||
                      out_result_q.target_valid)),
    "inconsistent flow flags")
  // Reset leaves no result pending.
  `ILBP_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !m_axis_tvalid_o,
    "result valid during reset")

endmodule
`default_nettype wire
